// ===== rtl/core/encpi_pkg.sv =====
package encpi_pkg;

    // Item kinds on the input tuser
    localparam logic [1:0] OP_EDGE_A = 2'd0;
    localparam logic [1:0] OP_EDGE_B = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN_P         = 3'd0;
    localparam logic [2:0] CFG_GAIN_I         = 3'd1;
    localparam logic [2:0] CFG_COUNTS_PER_REV = 3'd2;
    localparam logic [2:0] CFG_PERIOD_MS      = 3'd3;
    localparam logic [2:0] CFG_ACCEL_LIMIT    = 3'd4;

    localparam logic signed [17:0] RPM_SCALE   = 18'sd60000;
    localparam logic [7:0]         CMD_LIMIT   = 8'd130;
    localparam logic [7:0]         DUTY_OFFSET = 8'd90;
    // x/10 == (x*205) >> 11 for every 8-bit x
    localparam logic [7:0]         DIV10_MUL   = 8'd205;
    localparam int                 DIV10_SHIFT = 11;

    localparam int                 DIV_STEPS   = 48;
    localparam logic [5:0]         DIV_LAST    = 6'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DONE,
        S_DEN,
        S_NUM,
        S_DIV,
        S_SAT,
        S_MULP,
        S_MULI,
        S_ACC,
        S_DRIVE
    } t_state;

endpackage

// ===== rtl/core/encoder_pi_motor_speed_loop.sv =====
// Quadrature encoder counter with an incremental PI speed loop. Encoder edge items
// (tuser 0 = edge on A, 1 = edge on B) move the signed position count, and their result
// goes from S_DONE into the output register. For a control tick (tuser 2) one shared
// 33x18 signed multiplier forms counts_per_rev*period_ms, then delta*60000, a
// restoring divider retires one quotient bit a cycle over all 48 quotient bits, and the same
// multiplier then forms both PI products before the accumulator and drive update.
// Every item yields exactly one result; tuser 3 reports the current state. A new item
// is taken while the previous result still waits in the output register.
module encoder_pi_motor_speed_loop
    import encpi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // level_a[0], level_b[1], setpoint_rpm[17:2]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // position_count[31:0], speed_rpm[47:32],
                                        // drive_forward[48], drive_reverse[49], duty[57:50]
    output logic        m_axis_tuser    // updated[0]
);

    // configuration
    logic [15:0] r_gain_p, r_gain_i, r_cpr, r_period;
    logic [7:0]  r_accel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= 16'd256;
            r_gain_i <= 16'd0;
            r_cpr    <= 16'd1;
            r_period <= 16'd10;
            r_accel  <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN_P:         r_gain_p <= i_cfg_data;
                CFG_GAIN_I:         r_gain_i <= i_cfg_data;
                CFG_COUNTS_PER_REV: r_cpr    <= i_cfg_data;
                CFG_PERIOD_MS:      r_period <= i_cfg_data;
                CFG_ACCEL_LIMIT:    r_accel  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // state
    t_state r_state, n_state;

    logic [31:0]        r_count, r_prev_count;
    logic signed [15:0] r_speed;
    logic signed [16:0] r_prev_err, r_err;
    logic signed [23:0] r_acc;
    logic               r_fwd, r_rev;
    logic [7:0]         r_duty;
    logic               r_updated;
    logic signed [15:0] r_setpoint;

    logic [31:0]        r_den;
    logic [31:0]        r_rem;
    logic [47:0]        r_quo;
    logic               r_neg;
    logic [5:0]         r_div_cnt;
    logic signed [35:0] r_inc;

    logic               r_m_valid;
    logic [63:0]        r_m_data;
    logic               r_m_user;

    logic s_acc, out_free;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic [15:0]        cpr_eff, per_eff;
    logic [31:0]        delta;

    assign cpr_eff = (r_cpr == 16'd0) ? 16'd1 : r_cpr;
    assign per_eff = (r_period == 16'd0) ? 16'd1 : r_period;
    assign delta   = r_count - r_prev_count;

    always_comb begin
        mul_a = {delta[31], delta};
        mul_b = RPM_SCALE;
        case (r_state)
            S_DEN: begin
                mul_a = {17'd0, cpr_eff};
                mul_b = {2'd0, per_eff};
            end
            S_MULP: begin
                mul_a = {{16{r_err[16]}}, r_err};
                mul_b = {2'd0, r_gain_p};
            end
            S_MULI: begin
                mul_a = {{16{r_prev_err[16]}}, r_prev_err};
                mul_b = {2'd0, r_gain_i};
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    logic [50:0] num_mag;
    assign num_mag = mul_p[50] ? 51'(-mul_p) : mul_p;

    // divider step
    logic [32:0] div_t;
    logic        div_ge;
    assign div_t  = {r_rem, r_quo[47]};
    assign div_ge = (div_t >= {1'b0, r_den});

    // speed saturation and error
    logic signed [15:0] speed_sat;
    logic signed [16:0] err_new;
    always_comb begin
        if (r_neg)
            speed_sat = (r_quo >= 48'd32768) ? 16'sh8000 : 16'(-r_quo[15:0]);
        else
            speed_sat = (r_quo >= 48'd32768) ? 16'sh7FFF : r_quo[15:0];
    end
    assign err_new = {r_setpoint[15], r_setpoint} - {speed_sat[15], speed_sat};

    // increment clamp and accumulator saturation
    logic [15:0]        accel_x;
    logic [4:0]         accel_div;
    logic signed [35:0] lim;
    logic signed [13:0] inc_c;
    logic signed [24:0] acc_sum;
    logic signed [23:0] acc_sat;

    assign accel_x   = r_accel * DIV10_MUL;
    assign accel_div = accel_x[15:DIV10_SHIFT];
    assign lim       = {23'd0, accel_div, 8'd0};

    always_comb begin
        if (r_inc > lim)
            inc_c = lim[13:0];
        else if (r_inc < -lim)
            inc_c = 14'(-lim);
        else
            inc_c = r_inc[13:0];
    end

    assign acc_sum = {r_acc[23], r_acc} + {{11{inc_c[13]}}, inc_c};

    always_comb begin
        if (acc_sum > 25'sd8388607)
            acc_sat = 24'sh7FFFFF;
        else if (acc_sum < -25'sd8388608)
            acc_sat = 24'sh800000;
        else
            acc_sat = acc_sum[23:0];
    end

    // drive from command
    logic [23:0] acc_mag;
    logic [15:0] cmd_mag;
    logic [7:0]  cmd_cl;
    logic        cmd_neg;
    assign acc_mag = r_acc[23] ? 24'(-r_acc) : r_acc;
    assign cmd_mag = acc_mag[23:8];
    assign cmd_cl  = (cmd_mag > {8'd0, CMD_LIMIT}) ? CMD_LIMIT : cmd_mag[7:0];
    assign cmd_neg = r_acc[23] && (cmd_mag != 16'd0);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc)
                    n_state = (s_axis_tuser == OP_TICK) ? S_DEN : S_DONE;
            end
            S_DEN:   n_state = S_NUM;
            S_NUM:   n_state = S_DIV;
            S_DIV:   if (r_div_cnt == DIV_LAST) n_state = S_SAT;
            S_SAT:   n_state = S_MULP;
            S_MULP:  n_state = S_MULI;
            S_MULI:  n_state = S_ACC;
            S_ACC:   n_state = S_DRIVE;
            S_DRIVE: n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= 32'd0;
            r_prev_count <= 32'd0;
            r_speed      <= 16'sd0;
            r_prev_err   <= 17'sd0;
            r_acc        <= 24'sd0;
            r_fwd        <= 1'b0;
            r_rev        <= 1'b0;
            r_duty       <= 8'd0;
            r_m_valid    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        case (s_axis_tuser)
                            OP_EDGE_A: r_count <= (s_axis_tdata[0] == s_axis_tdata[1])
                                                  ? r_count + 32'd1 : r_count - 32'd1;
                            OP_EDGE_B: r_count <= (s_axis_tdata[0] != s_axis_tdata[1])
                                                  ? r_count + 32'd1 : r_count - 32'd1;
                            default: ;
                        endcase
                    end
                end
                S_NUM:  r_prev_count <= r_count;
                S_SAT:  r_speed <= speed_sat;
                S_MULI: r_prev_err <= r_err;
                S_ACC:  r_acc <= acc_sat;
                S_DRIVE: begin
                    r_fwd  <= !cmd_neg;
                    r_rev  <= cmd_neg;
                    r_duty <= (cmd_mag == 16'd0) ? 8'd0 : cmd_cl + DUTY_OFFSET;
                end
                default: ;
            endcase

            if (r_state == S_DONE && out_free)
                r_m_valid <= 1'b1;
            else if (m_axis_tready)
                r_m_valid <= 1'b0;
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_setpoint <= s_axis_tdata[17:2];
                    r_updated  <= (s_axis_tuser == OP_TICK);
                end
            end
            S_DEN: r_den <= mul_p[31:0];
            S_NUM: begin
                r_quo     <= num_mag[47:0];
                r_neg     <= mul_p[50];
                r_rem     <= 32'd0;
                r_div_cnt <= 6'd0;
            end
            S_DIV: begin
                r_rem     <= div_ge ? 32'(div_t - {1'b0, r_den}) : div_t[31:0];
                r_quo     <= {r_quo[46:0], div_ge};
                r_div_cnt <= r_div_cnt + 6'd1;
            end
            S_SAT:  r_err <= err_new;
            S_MULP: r_inc <= mul_p[35:0];
            S_MULI: r_inc <= r_inc + mul_p[35:0];
            S_DONE: begin
                if (out_free) begin
                    r_m_data <= {6'd0, r_duty, r_rev, r_fwd, r_speed, r_count};
                    r_m_user <= r_updated;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_tick_starts_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_axis_tuser == OP_TICK |=> r_state == S_DEN)
        else $error("tick did not start the speed sequence");

    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div_cnt <= DIV_LAST)
        else $error("divider step count out of range");

    a_drive_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fwd && r_rev))
        else $error("both bridge inputs high");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty == 8'd0 || (r_duty > DUTY_OFFSET && r_duty <= CMD_LIMIT + DUTY_OFFSET))
        else $error("duty outside its range");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && out_free |=> r_m_valid && r_state == S_IDLE)
        else $error("result not loaded on completion");
`endif

endmodule

// ===== tb/sv/speed_loop_checker.sv =====
module speed_loop_checker
    import encpi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // level_a[0], level_b[1], setpoint_rpm[17:2]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // position_count[31:0], speed_rpm[47:32],
                                        // drive_forward[48], drive_reverse[49], duty[57:50]
    input  logic        m_axis_tuser,   // updated[0]

    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] position;
        logic [15:0] speed;
        logic        forward;
        logic        reverse;
        logic [7:0]  duty;
        logic        updated;
    } t_loop_report;

    // shadow copy of the configuration registers
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] counts_per_rev;
    logic [15:0] period_ms;
    logic [7:0]  accel_limit;

    // shadow copy of the controller state
    logic [31:0]        position;
    logic [31:0]        tick_position;
    logic signed [15:0] speed;
    logic signed [16:0] last_error;
    logic signed [23:0] command_acc;
    logic               drive_fwd;
    logic               drive_rev;
    logic [7:0]         drive_duty;

    t_loop_report reports_due[$];
    int           errors  = 0;
    int           pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic run_control_tick(input logic signed [15:0] setpoint);
        longint delta, den, rate, err, inc, lim, acc, cmd;
        delta = longint'(signed'(position - tick_position));
        den   = longint'((counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev)
              * longint'((period_ms == 16'd0) ? 16'd1 : period_ms);
        tick_position = position;
        rate  = delta * longint'(RPM_SCALE) / den;
        speed = 16'(clamp(rate, -32768, 32767));

        err = longint'(setpoint) - longint'(speed);
        inc = longint'(gain_p) * err + longint'(gain_i) * longint'(last_error);
        lim = longint'(accel_limit / 8'd10) * 256;
        inc = clamp(inc, -lim, lim);
        acc = clamp(longint'(command_acc) + inc, -8388608, 8388607);
        command_acc = 24'(acc);
        last_error  = 17'(err);

        // integer part truncates toward zero
        cmd = clamp(acc / 256, -longint'(CMD_LIMIT), longint'(CMD_LIMIT));
        drive_fwd  = (cmd >= 0);
        drive_rev  = (cmd < 0);
        drive_duty = (cmd == 0) ? 8'd0
                   : 8'(((cmd < 0) ? -cmd : cmd) + longint'(DUTY_OFFSET));
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_loop_report got;
        t_loop_report want;
        logic         lvl_a;
        logic         lvl_b;
        if (!i_rst_n) begin
            gain_p         = 16'd256;
            gain_i         = 16'd0;
            counts_per_rev = 16'd1;
            period_ms      = 16'd10;
            accel_limit    = 8'd255;
            position       = '0;
            tick_position  = '0;
            speed          = '0;
            last_error     = '0;
            command_acc    = '0;
            drive_fwd      = 1'b0;
            drive_rev      = 1'b0;
            drive_duty     = '0;
            reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GAIN_P:         gain_p         = i_cfg_data;
                    CFG_GAIN_I:         gain_i         = i_cfg_data;
                    CFG_COUNTS_PER_REV: counts_per_rev = i_cfg_data;
                    CFG_PERIOD_MS:      period_ms      = i_cfg_data;
                    CFG_ACCEL_LIMIT:    accel_limit    = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                lvl_a = s_axis_tdata[0];
                lvl_b = s_axis_tdata[1];
                case (s_axis_tuser)
                    OP_EDGE_A: position += (lvl_a == lvl_b) ? 32'd1 : 32'hFFFF_FFFF;
                    OP_EDGE_B: position += (lvl_a != lvl_b) ? 32'd1 : 32'hFFFF_FFFF;
                    OP_TICK:   run_control_tick(s_axis_tdata[17:2]);
                    default: ;
                endcase
                reports_due.push_back('{position, speed, drive_fwd, drive_rev, drive_duty,
                                        s_axis_tuser == OP_TICK});
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[48],
                        m_axis_tdata[49], m_axis_tdata[57:50], m_axis_tuser};
                if (reports_due.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    errors++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("position_count", signed'(want.position), signed'(got.position));
                    check_field("speed_rpm", signed'(want.speed), signed'(got.speed));
                    check_field("drive_forward", want.forward, got.forward);
                    check_field("drive_reverse", want.reverse, got.reverse);
                    check_field("duty", want.duty, got.duty);
                    check_field("updated", want.updated, got.updated);
                end
            end
        end
        pending = reports_due.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import encpi_pkg::*;

    localparam logic [1:0] OP_IDLE     = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         SEGMENTS    = 8;
    localparam int         SEG_ITEMS   = 116;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_addr    = '0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // level_a[0], level_b[1], setpoint_rpm[17:2]
    logic [1:0]  s_axis_tuser  = '0;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // position_count[31:0], speed_rpm[47:32],
                                       // drive_forward[48], drive_reverse[49], duty[57:50]
    logic        m_axis_tuser;         // updated[0]

    int errors;
    int pending;
    int cycles        = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    encoder_pi_motor_speed_loop uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    speed_loop_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] op, input logic lvl_a, input logic lvl_b,
                             input logic [15:0] setpoint);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, setpoint, lvl_b, lvl_a};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid and hold until every expected result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] gp, input logic [15:0] gi,
                                 input logic [15:0] cpr, input logic [15:0] per,
                                 input logic [7:0] accel);
        wait_drained();
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_COUNTS_PER_REV, cpr);
        write_reg(CFG_PERIOD_MS, per);
        write_reg(CFG_ACCEL_LIMIT, {8'd0, accel});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic       lvl_a;
        logic       lvl_b;
        logic       fwd_dir;
        logic [1:0] op;
        int         r;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero command, all level patterns, unused op, then drive to the forward limit and back into reverse
        push_item(OP_TICK, 1'b0, 1'b0, 16'h0000);
        push_item(OP_EDGE_A, 1'b1, 1'b1, 16'h0000);
        push_item(OP_EDGE_A, 1'b1, 1'b0, 16'h0000);
        push_item(OP_EDGE_B, 1'b0, 1'b1, 16'hFFFF);
        push_item(OP_EDGE_B, 1'b0, 1'b0, 16'hFFFF);
        push_item(OP_IDLE, 1'b1, 1'b1, 16'h8000);
        repeat (6) push_item(OP_TICK, 1'b1, 1'b0, 16'h7FFF);
        repeat (7) push_item(OP_TICK, 1'b0, 1'b1, 16'h8000);
        push_item(OP_TICK, 1'b1, 1'b1, 16'h0000);

        lvl_a   = 1'b0;
        lvl_b   = 1'b0;
        fwd_dir = 1'b1;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: load_settings(16'd256, 16'd0, 16'd1, 16'd10, 8'd255);
                1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
                2: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'd9);
                3: load_settings(16'd512, 16'd128, 16'd4, 16'd1, 8'd255);
                4: load_settings(16'd1, 16'd0, 16'd1, 16'd1, 8'd10);
                default: load_settings(16'($urandom_range(1023)), 16'($urandom_range(511)),
                                       16'($urandom_range(1, 64)), 16'($urandom_range(1, 20)),
                                       8'($urandom_range(255)));
            endcase
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase

            for (int n = 0; n < SEG_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 68) begin
                    // follow the quadrature sequence, reversing now and then
                    if ($urandom_range(15) == 0) fwd_dir = ~fwd_dir;
                    if (fwd_dir == (lvl_a == lvl_b)) begin
                        lvl_b = ~lvl_b;
                        op    = OP_EDGE_B;
                    end else begin
                        lvl_a = ~lvl_a;
                        op    = OP_EDGE_A;
                    end
                    push_item(op, lvl_a, lvl_b, 16'($urandom));
                end else if (r < 85) begin
                    if ($urandom_range(7) == 0)
                        push_item(OP_TICK, 1'($urandom), 1'($urandom),
                                  $urandom_range(1) ? 16'h7FFF : 16'h8000);
                    else
                        push_item(OP_TICK, 1'($urandom), 1'($urandom), 16'($urandom));
                end else if (r < 94) begin
                    push_item($urandom_range(1) ? OP_EDGE_B : OP_EDGE_A,
                              1'($urandom), 1'($urandom), 16'($urandom));
                end else begin
                    push_item(OP_IDLE, 1'($urandom), 1'($urandom), 16'($urandom));
                end
            end
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/encpi_pkg.sv
rtl/core/encoder_pi_motor_speed_loop.sv
tb/sv/speed_loop_checker.sv
tb/sv/tb.sv
